// ===== sv/ict_pkg.sv =====
package ict_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NUM_TAPS_DEF    = 16;

    localparam int FREQ_W = 34;
    localparam int VAL_W  = 16;
    localparam int TIDX_W = 4;
    localparam int NT_W   = 5;
    localparam int CADR_W = 4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [CADR_W-1:0] CFG_MODE  = 4'd0;
    localparam logic [CADR_W-1:0] CFG_NTAPS = 4'd1;

    localparam logic [NT_W-1:0] NTAPS_RST = 5'd16;

    typedef enum logic [2:0] {
        SEL_SC = 3'd0,
        SEL_DL = 3'd1,
        SEL_DR = 3'd2,
        SEL_DI = 3'd3,
        SEL_IC = 3'd4,
        SEL_QI = 3'd5
    } sel_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sc;
        logic signed [VAL_W-1:0] dl;
        logic signed [VAL_W-1:0] dr;
        logic signed [VAL_W-1:0] di;
    } ent_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] ic;
        logic signed [VAL_W-1:0] qi;
    } tap_t;

    typedef struct packed {
        logic       in_ready;
        logic       capture;
        logic       clear_count;
        logic       scan_init;
        logic       scan_read;
        logic       scan_step;
        logic       set_slot_match;
        logic       set_ends;
        logic       shift_init;
        logic       shift_read;
        logic       shift_write;
        logic       insert;
        logic       write_entry;
        logic       rd_hi;
        logic       cap_lo;
        logic       cap_hi;
        logic       sel_init;
        logic       sel_next;
        logic       lerp_start;
        logic       k_init;
        logic       k_next;
        logic       out_load;
        logic       emit_tap;
        logic [1:0] emit_status;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_op;
        logic [1:0] op;
        logic       count_zero;
        logic       scan_end;
        logic       key_lt;
        logic       key_eq;
        logic       table_full;
        logic       shift_done;
        logic       lerp_done;
        logic       sel_last;
        logic       k_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== sv/ict_ifs.sv =====
interface ict_req_if import ict_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [FREQ_W-1:0]        freq_hz;
    logic [TIDX_W-1:0]        tap_index;
    logic signed [VAL_W-1:0]  icross_tap;
    logic signed [VAL_W-1:0]  qinline_tap;
    logic signed [VAL_W-1:0]  scale_val;
    logic signed [VAL_W-1:0]  delay_val;
    logic signed [VAL_W-1:0]  dc_offset_re;
    logic signed [VAL_W-1:0]  dc_offset_im;

    modport source (output valid, op, freq_hz, tap_index, icross_tap, qinline_tap,
                    scale_val, delay_val, dc_offset_re, dc_offset_im,
                    input ready);
    modport sink (input valid, op, freq_hz, tap_index, icross_tap, qinline_tap,
                  scale_val, delay_val, dc_offset_re, dc_offset_im,
                  output ready);
endinterface

interface ict_rsp_if import ict_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [TIDX_W-1:0]        out_tap_index;
    logic signed [VAL_W-1:0]  out_icross;
    logic signed [VAL_W-1:0]  out_qinline;
    logic signed [VAL_W-1:0]  out_scaling;
    logic signed [VAL_W-1:0]  out_delay;
    logic signed [VAL_W-1:0]  out_dc_re;
    logic signed [VAL_W-1:0]  out_dc_im;
    logic                     last;

    modport source (output valid, status, out_tap_index, out_icross, out_qinline,
                    out_scaling, out_delay, out_dc_re, out_dc_im, last,
                    input ready);
    modport sink (input valid, status, out_tap_index, out_icross, out_qinline,
                  out_scaling, out_delay, out_dc_re, out_dc_im, last,
                  output ready);
endinterface

interface ict_cfg_if import ict_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CADR_W-1:0] addr;
    logic [NT_W-1:0]   wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== sv/ict_lerp.sv =====
module ict_lerp
    import ict_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [VAL_W-1:0] y0,
    input  logic signed [VAL_W-1:0] y1,
    input  logic [FREQ_W-1:0]       num,
    input  logic [FREQ_W-1:0]       den,
    output logic                    done,
    output logic signed [VAL_W-1:0] y
);

    localparam int QW   = VAL_W + 1;
    localparam int PW   = VAL_W + FREQ_W;
    localparam int NUMW = PW + 2;
    localparam int DW   = FREQ_W + 1;
    localparam int RW   = NUMW - QW;

    logic signed [VAL_W-1:0] y0_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic [VAL_W-1:0]        mag_reg;
    logic [FREQ_W-1:0]       num_reg;
    logic [DW-1:0]           d2_reg;
    logic [RW-1:0]           rem_reg;
    logic [QW-1:0]           qs_reg;
    logic [4:0]              cnt_reg;
    logic                    mul_reg;
    logic                    run_reg;
    logic                    done_reg;

    logic signed [VAL_W:0] diff;
    logic [VAL_W:0]        mag;
    logic [PW-1:0]         prod;
    logic [NUMW-1:0]       numer;
    logic [RW:0]           r2;
    logic                  ge;
    logic signed [VAL_W+1:0] sum;

    assign diff  = {y1[VAL_W-1], y1} - {y0[VAL_W-1], y0};
    assign mag   = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
    assign prod  = mag_reg * num_reg;
    assign numer = {1'b0, prod, 1'b0} + NUMW'(d2_reg[DW-1:1]);
    assign r2    = {rem_reg, qs_reg[QW-1]};
    assign ge    = r2 >= {1'b0, d2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                mul_reg <= 1'b0;
                run_reg <= 1'b1;
                cnt_reg <= 5'(QW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y0_reg   <= y0;
            neg_reg  <= diff[VAL_W];
            zero_reg <= (diff == '0);
            mag_reg  <= mag[VAL_W-1:0];
            num_reg  <= num;
            d2_reg   <= {den, 1'b0};
        end
        else if (mul_reg)
        begin
            rem_reg <= numer[NUMW-1:QW];
            qs_reg  <= numer[QW-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? RW'(r2 - {1'b0, d2_reg}) : r2[RW-1:0];
            qs_reg  <= {qs_reg[QW-2:0], ge};
        end
    end

    // quotient never exceeds the magnitude, so the sum stays within y0..y1
    assign sum  = neg_reg ? ({{2{y0_reg[VAL_W-1]}}, y0_reg} - {1'b0, qs_reg})
                          : ({{2{y0_reg[VAL_W-1]}}, y0_reg} + {1'b0, qs_reg});
    assign y    = zero_reg ? y0_reg : sum[VAL_W-1:0];
    assign done = done_reg;

endmodule

// ===== sv/ict_datapath.sv =====
module ict_datapath
    import ict_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NUM_TAPS    = NUM_TAPS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    ict_req_if.sink       req,
    ict_rsp_if.source     rsp,
    ict_cfg_if.sink       cfg,
    input  cmd_t          cmd,
    output sts_t          sts
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int NW = $clog2(NUM_TAPS + 1);
    localparam int AW = SW + TW;
    localparam int RKW = FREQ_W + SW;

    // sorted key list: {key, slot}; entries themselves never move
    logic [RKW-1:0] rank_mem [MAX_ENTRIES];
    ent_t           ent_mem  [MAX_ENTRIES];
    tap_t           tap_mem  [2**AW];

    logic [RKW-1:0] rank_rd_reg;
    ent_t           ent_rd_reg;
    tap_t           tap_rd_reg;

    logic              mode_reg;
    logic [NT_W-1:0]   ntaps_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [NW-1:0]     k_reg;
    logic [RKW-1:0]    prev_reg;
    logic [SW-1:0]     wr_slot_reg;
    logic [SW-1:0]     lo_slot_reg;
    logic [SW-1:0]     hi_slot_reg;
    logic [FREQ_W-1:0] lo_key_reg;
    logic [FREQ_W-1:0] hi_key_reg;
    logic              take_hi_reg;
    sel_t              sel_reg;

    logic [1:0]         op_reg;
    logic [FREQ_W-1:0]  f_reg;
    logic [TIDX_W-1:0]  tidx_reg;
    tap_t               tin_reg;
    ent_t               ein_reg;

    ent_t ent_lo_reg, ent_hi_reg;
    tap_t tap_lo_reg, tap_hi_reg;
    logic signed [VAL_W-1:0] res_sc_reg, res_dl_reg, res_dr_reg, res_di_reg;
    logic signed [VAL_W-1:0] res_ic_reg, res_qi_reg;

    logic                    out_valid_reg;
    logic [1:0]              out_st_reg;
    logic [TIDX_W-1:0]       out_tap_reg;
    logic signed [VAL_W-1:0] out_ic_reg, out_qi_reg, out_sc_reg;
    logic signed [VAL_W-1:0] out_dl_reg, out_dr_reg, out_di_reg;
    logic                    out_last_reg;

    logic [FREQ_W-1:0] rank_key;
    logic [SW-1:0]     rank_slot;
    logic [FREQ_W-1:0] prev_key;
    logic [SW-1:0]     prev_slot;
    logic [SW-1:0]     rank_raddr;
    logic [SW-1:0]     ent_raddr;
    logic [NT_W-1:0]   nt_clip;
    logic [NW-1:0]     n_taps;
    logic              out_free;
    logic              tap_ok;

    logic [SW-1:0]     lo_slot_n, hi_slot_n;
    logic [FREQ_W-1:0] lo_key_n, hi_key_n;
    logic              interp_n;

    logic signed [VAL_W-1:0] v_lo, v_hi, ly0, ly1, ly;
    logic                    lerp_done;

    assign rank_key  = rank_rd_reg[RKW-1:SW];
    assign rank_slot = rank_rd_reg[SW-1:0];
    assign prev_key  = prev_reg[RKW-1:SW];
    assign prev_slot = prev_reg[SW-1:0];

    assign nt_clip = (ntaps_reg == '0) ? NT_W'(1) : ntaps_reg;
    assign n_taps  = (32'(nt_clip) > NUM_TAPS) ? NW'(NUM_TAPS) : NW'(nt_clip);
    assign out_free = !out_valid_reg || rsp.ready;
    assign tap_ok   = 32'(tidx_reg) < NUM_TAPS;

    // ---------------- configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            ntaps_reg <= NTAPS_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.addr == CFG_MODE)
            begin
                mode_reg <= cfg.wdata[0];
            end
            else if (cfg.addr == CFG_NTAPS)
            begin
                ntaps_reg <= cfg.wdata;
            end
        end
    end

    // ---------------- memories
    assign rank_raddr = cmd.shift_read ? SW'(j_reg - CW'(1)) : i_reg[SW-1:0];
    assign ent_raddr  = cmd.rd_hi ? hi_slot_reg : lo_slot_reg;

    always_ff @(posedge clk)
    begin
        rank_rd_reg <= rank_mem[rank_raddr];
        if (cmd.shift_write)
        begin
            rank_mem[j_reg[SW-1:0]] <= rank_rd_reg;
        end
        else if (cmd.insert)
        begin
            rank_mem[i_reg[SW-1:0]] <= {f_reg, count_reg[SW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        ent_rd_reg <= ent_mem[ent_raddr];
        if (cmd.write_entry)
        begin
            ent_mem[wr_slot_reg] <= ein_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tap_rd_reg <= tap_mem[{ent_raddr, TW'(k_reg)}];
        if (cmd.write_entry && tap_ok)
        begin
            tap_mem[{wr_slot_reg, TW'(tidx_reg)}] <= tin_reg;
        end
    end

    // ---------------- bracket selection
    always_comb
    begin
        lo_slot_n = rank_slot;
        hi_slot_n = rank_slot;
        lo_key_n  = rank_key;
        hi_key_n  = rank_key;
        interp_n  = 1'b0;
        if (i_reg == count_reg)
        begin
            lo_slot_n = prev_slot;
            hi_slot_n = prev_slot;
            lo_key_n  = prev_key;
            hi_key_n  = prev_key;
        end
        else if (i_reg != '0)
        begin
            lo_slot_n = prev_slot;
            lo_key_n  = prev_key;
            interp_n  = 1'b1;
        end
    end

    // ---------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            sel_reg       <= SEL_SC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.insert)
            begin
                count_reg <= count_reg + CW'(1);
            end

            if (cmd.scan_init)
            begin
                i_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                i_reg <= i_reg + CW'(1);
            end

            if (cmd.shift_init)
            begin
                j_reg <= count_reg;
            end
            else if (cmd.shift_write)
            begin
                j_reg <= j_reg - CW'(1);
            end

            if (cmd.k_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_next)
            begin
                k_reg <= k_reg + NW'(1);
            end

            if (cmd.sel_init)
            begin
                sel_reg <= (k_reg == '0) ? SEL_SC : SEL_IC;
            end
            else if (cmd.sel_next)
            begin
                unique case (sel_reg)
                    SEL_SC:  sel_reg <= SEL_DL;
                    SEL_DL:  sel_reg <= SEL_DR;
                    SEL_DR:  sel_reg <= SEL_DI;
                    SEL_DI:  sel_reg <= SEL_IC;
                    SEL_IC:  sel_reg <= SEL_QI;
                    default: sel_reg <= SEL_QI;
                endcase
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req.op;
            f_reg    <= req.freq_hz;
            tidx_reg <= req.tap_index;
            tin_reg  <= '{ic: req.icross_tap, qi: req.qinline_tap};
            ein_reg  <= '{sc: req.scale_val, dl: req.delay_val,
                          dr: req.dc_offset_re, di: req.dc_offset_im};
        end
        if (cmd.scan_step)
        begin
            prev_reg <= rank_rd_reg;
        end
        if (cmd.set_slot_match)
        begin
            wr_slot_reg <= rank_slot;
        end
        else if (cmd.insert)
        begin
            wr_slot_reg <= count_reg[SW-1:0];
        end
        if (cmd.set_ends)
        begin
            lo_slot_reg <= lo_slot_n;
            hi_slot_reg <= hi_slot_n;
            lo_key_reg  <= lo_key_n;
            hi_key_reg  <= hi_key_n;
            // nearest: tie goes to the lower entry
            take_hi_reg <= interp_n && ((hi_key_n - f_reg) < (f_reg - lo_key_n));
        end
        if (cmd.cap_lo)
        begin
            ent_lo_reg <= ent_rd_reg;
            tap_lo_reg <= tap_rd_reg;
        end
        if (cmd.cap_hi)
        begin
            ent_hi_reg <= ent_rd_reg;
            tap_hi_reg <= tap_rd_reg;
        end
        if (lerp_done)
        begin
            unique case (sel_reg)
                SEL_SC:  res_sc_reg <= ly;
                SEL_DL:  res_dl_reg <= ly;
                SEL_DR:  res_dr_reg <= ly;
                SEL_DI:  res_di_reg <= ly;
                SEL_IC:  res_ic_reg <= ly;
                default: res_qi_reg <= ly;
            endcase
        end
        if (cmd.out_load)
        begin
            out_st_reg   <= cmd.emit_tap ? ST_OK : cmd.emit_status;
            out_tap_reg  <= cmd.emit_tap ? TIDX_W'(k_reg) : '0;
            out_ic_reg   <= cmd.emit_tap ? res_ic_reg : '0;
            out_qi_reg   <= cmd.emit_tap ? res_qi_reg : '0;
            out_sc_reg   <= cmd.emit_tap ? res_sc_reg : '0;
            out_dl_reg   <= cmd.emit_tap ? res_dl_reg : '0;
            out_dr_reg   <= cmd.emit_tap ? res_dr_reg : '0;
            out_di_reg   <= cmd.emit_tap ? res_di_reg : '0;
            out_last_reg <= cmd.emit_tap ? sts.k_last : 1'b1;
        end
    end

    // ---------------- interpolation operands
    always_comb
    begin
        unique case (sel_reg)
            SEL_SC:
            begin
                v_lo = ent_lo_reg.sc;
                v_hi = ent_hi_reg.sc;
            end
            SEL_DL:
            begin
                v_lo = ent_lo_reg.dl;
                v_hi = ent_hi_reg.dl;
            end
            SEL_DR:
            begin
                v_lo = ent_lo_reg.dr;
                v_hi = ent_hi_reg.dr;
            end
            SEL_DI:
            begin
                v_lo = ent_lo_reg.di;
                v_hi = ent_hi_reg.di;
            end
            SEL_IC:
            begin
                v_lo = tap_lo_reg.ic;
                v_hi = tap_hi_reg.ic;
            end
            default:
            begin
                v_lo = tap_lo_reg.qi;
                v_hi = tap_hi_reg.qi;
            end
        endcase
        // nearest mode: equal end points make the unit return the pick as is
        ly0 = v_lo;
        ly1 = v_hi;
        if (mode_reg && sel_reg != SEL_DR && sel_reg != SEL_DI)
        begin
            ly0 = take_hi_reg ? v_hi : v_lo;
            ly1 = ly0;
        end
    end

    ict_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.lerp_start),
        .y0    (ly0),
        .y1    (ly1),
        .num   (f_reg - lo_key_reg),
        .den   (hi_key_reg - lo_key_reg),
        .done  (lerp_done),
        .y     (ly)
    );

    // ---------------- ports and status
    assign req.ready = cmd.in_ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_st_reg;
    assign rsp.out_tap_index = out_tap_reg;
    assign rsp.out_icross    = out_ic_reg;
    assign rsp.out_qinline   = out_qi_reg;
    assign rsp.out_scaling   = out_sc_reg;
    assign rsp.out_delay     = out_dl_reg;
    assign rsp.out_dc_re     = out_dr_reg;
    assign rsp.out_dc_im     = out_di_reg;
    assign rsp.last          = out_last_reg;

    assign sts.in_valid   = req.valid;
    assign sts.in_op      = req.op;
    assign sts.op         = op_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_end   = (i_reg == count_reg);
    assign sts.key_lt     = rank_key < f_reg;
    assign sts.key_eq     = rank_key == f_reg;
    assign sts.table_full = (count_reg == CW'(MAX_ENTRIES));
    assign sts.shift_done = (j_reg == i_reg);
    assign sts.lerp_done  = lerp_done;
    assign sts.sel_last   = (sel_reg == SEL_QI);
    assign sts.k_last     = ((k_reg + NW'(1)) == n_taps);
    assign sts.out_free   = out_free;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result overwritten before it was taken");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !sts.table_full && sts.shift_done)
        else $error("insert into full table or before shift finished");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert && !cmd.clear_count |=> count_reg == $past(count_reg) + CW'(1))
        else $error("entry count did not advance on insert");
`endif

endmodule

// ===== sv/ict_ctrl.sv =====
module ict_ctrl
    import ict_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_SCAN_RD  = 14'b00000000000010,
        S_SCAN_CMP = 14'b00000000000100,
        S_SHIFT_RD = 14'b00000000001000,
        S_SHIFT_WR = 14'b00000000010000,
        S_INSERT   = 14'b00000000100000,
        S_WR_ENT   = 14'b00000001000000,
        S_RD_LO    = 14'b00000010000000,
        S_RD_HI    = 14'b00000100000000,
        S_CAP_HI   = 14'b00001000000000,
        S_L_START  = 14'b00010000000000,
        S_L_WAIT   = 14'b00100000000000,
        S_EMIT_TAP = 14'b01000000000000,
        S_EMIT_ST  = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = code_reg;
        state_next      = state_reg;
        code_next       = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.in_op == OP_CLEAR)
                    begin
                        cmd.clear_count = 1'b1;
                        code_next       = ST_OK;
                        state_next      = S_EMIT_ST;
                    end
                    else if (sts.in_op == OP_WRITE)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                    else if (sts.in_op == OP_QUERY)
                    begin
                        if (sts.count_zero)
                        begin
                            code_next  = ST_EMPTY;
                            state_next = S_EMIT_ST;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_RD;
                        end
                    end
                end
            end

            S_SCAN_RD, S_SCAN_CMP:
            begin
                if (state_reg == S_SCAN_RD && !sts.scan_end)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_CMP;
                end
                else if (state_reg == S_SCAN_CMP && sts.key_lt)
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else if (sts.op == OP_QUERY)
                begin
                    cmd.set_ends = 1'b1;
                    cmd.k_init   = 1'b1;
                    state_next   = S_RD_LO;
                end
                else if (!sts.scan_end && sts.key_eq)
                begin
                    cmd.set_slot_match = 1'b1;
                    state_next         = S_WR_ENT;
                end
                else if (sts.table_full)
                begin
                    code_next  = ST_FULL;
                    state_next = S_EMIT_ST;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.shift_read = 1'b1;
                    state_next     = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                cmd.shift_write = 1'b1;
                state_next      = S_SHIFT_RD;
            end

            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_WR_ENT;
            end

            S_WR_ENT:
            begin
                cmd.write_entry = 1'b1;
                code_next       = ST_OK;
                state_next      = S_EMIT_ST;
            end

            S_RD_LO:
            begin
                state_next = S_RD_HI;
            end

            S_RD_HI:
            begin
                cmd.rd_hi  = 1'b1;
                cmd.cap_lo = 1'b1;
                state_next = S_CAP_HI;
            end

            S_CAP_HI:
            begin
                cmd.cap_hi   = 1'b1;
                cmd.sel_init = 1'b1;
                state_next   = S_L_START;
            end

            S_L_START:
            begin
                cmd.lerp_start = 1'b1;
                state_next     = S_L_WAIT;
            end

            S_L_WAIT:
            begin
                if (sts.lerp_done)
                begin
                    if (sts.sel_last)
                    begin
                        state_next = S_EMIT_TAP;
                    end
                    else
                    begin
                        cmd.sel_next = 1'b1;
                        state_next   = S_L_START;
                    end
                end
            end

            S_EMIT_TAP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.emit_tap = 1'b1;
                    if (sts.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_next = 1'b1;
                        state_next = S_RD_LO;
                    end
                end
            end

            S_EMIT_ST:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state lost its one-hot code");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> state_reg == S_IDLE)
        else $error("transaction taken while busy");

    a_lerp_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lerp_start |=> state_reg == S_L_WAIT)
        else $error("interpolation started without waiting for it");
`endif

endmodule

// ===== sv/interpolating_calibration_table_unit.sv =====
// Frequency-keyed calibration table with linear interpolation.
// Channels: req (sink) carries write / clear / query transactions, rsp
// (source) carries result transactions, cfg (sink, always ready) writes
// the nearest-mode flag (index 0) and num_taps (index 1), which the user
// does only while idle; the block does not enforce it. A write or clear
// gives one result; a query gives one result per tap in use, last marking
// the final one; a query on an empty table gives one result with the
// empty status. Throughput: one transaction is worked on at a time. The
// key search walks the sorted key memory, reading then comparing each key
// (up to MAX_ENTRIES); inserting a new key shifts the sorted list with a
// read and a write per entry above it. A query then runs six values for
// the first tap and two per further tap through the shared serial divider
// (17 quotient bits, one a cycle) that forms every interpolated value.
// Reset: table empty, linear mode, 16 taps; the memories are not cleared.
// Stall: a finished result waits in the output register; the next request
// transaction is taken meanwhile, and the block holds when it has another
// result to place before the receiver takes the waiting one.
module interpolating_calibration_table_unit
    import ict_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NUM_TAPS    = NUM_TAPS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ict_req_if.sink   req,
    ict_rsp_if.source rsp,
    ict_cfg_if.sink   cfg
);

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    ict_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ict_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUM_TAPS    (NUM_TAPS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ict_pkg::*;

    localparam int  TAPS        = NUM_TAPS_DEF;
    localparam int  SLOTS       = MAX_ENTRIES_DEF;
    // Quiet time before a register write or the end: a worst-case key search
    // plus a full shift of the sorted list, with margin.
    localparam int  SETTLE      = 600;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  MAX_PRINTS  = 40;

    // op code with no meaning: taken, no result
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [1:0]              op;
        logic [FREQ_W-1:0]       freq;
        logic [TIDX_W-1:0]       tap;
        logic signed [VAL_W-1:0] ic;
        logic signed [VAL_W-1:0] qi;
        logic signed [VAL_W-1:0] sc;
        logic signed [VAL_W-1:0] dl;
        logic signed [VAL_W-1:0] dr;
        logic signed [VAL_W-1:0] di;
    } cal_req_t;

    typedef struct {
        logic [1:0]              status;
        logic [TIDX_W-1:0]       tap;
        logic signed [VAL_W-1:0] ic;
        logic signed [VAL_W-1:0] qi;
        logic signed [VAL_W-1:0] sc;
        logic signed [VAL_W-1:0] dl;
        logic signed [VAL_W-1:0] dr;
        logic signed [VAL_W-1:0] di;
        logic                    last;
    } cal_rsp_t;

    typedef struct {
        logic [CADR_W-1:0] addr;
        logic [NT_W-1:0]   data;
    } reg_wr_t;

    logic clk;
    logic rst_n;

    ict_req_if req_if ();
    ict_rsp_if rsp_if ();
    ict_cfg_if cfg_if ();

    interpolating_calibration_table_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the calibration table, updated as transactions are taken
    // ------------------------------------------------------------------
    logic [FREQ_W-1:0]       sh_key [SLOTS];
    logic signed [VAL_W-1:0] sh_sc  [SLOTS];
    logic signed [VAL_W-1:0] sh_dl  [SLOTS];
    logic signed [VAL_W-1:0] sh_dr  [SLOTS];
    logic signed [VAL_W-1:0] sh_di  [SLOTS];
    logic signed [VAL_W-1:0] sh_ic  [SLOTS][TAPS];
    logic signed [VAL_W-1:0] sh_qi  [SLOTS][TAPS];
    int                      sh_count;
    logic                    sh_nearest;
    logic [NT_W-1:0]         sh_ntaps;

    cal_rsp_t  expected_rsp [$];
    cal_req_t  pending_req  [$];
    reg_wr_t   pending_reg  [$];
    cal_req_t  cur_req;

    int        tx_idle_pct;
    int        rx_idle_pct;
    int        mismatches;
    int        cycles;
    int        n_results;
    int        n_queries;
    int        n_full;
    int        n_empty;
    int        n_regs;

    // keys handed out by the stimulus, used to aim queries near real entries
    logic [FREQ_W-1:0] gen_keys [$];

    // Rounded linear blend, halves away from zero; never leaves [y0, y1].
    function automatic logic signed [VAL_W-1:0] blend(
        logic [FREQ_W-1:0] f, logic [FREQ_W-1:0] f0, logic signed [VAL_W-1:0] y0,
        logic [FREQ_W-1:0] f1, logic signed [VAL_W-1:0] y1);
        longint            diff;
        longint unsigned   mag;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        longint            res;
        diff = longint'(y1) - longint'(y0);
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        num  = longint'(f) - longint'(f0);
        den  = longint'(f1) - longint'(f0);
        if (den == 0)
        begin
            return y0;
        end
        q   = (2 * mag * num + den) / (2 * den);
        res = (diff < 0) ? longint'(y0) - longint'(q) : longint'(y0) + longint'(q);
        return res[VAL_W-1:0];
    endfunction

    function automatic cal_rsp_t status_only(logic [1:0] st);
        cal_rsp_t r;
        r = '{status: st, tap: '0, ic: '0, qi: '0, sc: '0, dl: '0, dr: '0, di: '0,
              last: 1'b1};
        return r;
    endfunction

    function automatic int first_not_below(logic [FREQ_W-1:0] f);
        int i;
        i = 0;
        while (i < sh_count && sh_key[i] < f)
            i++;
        return i;
    endfunction

    // Apply one taken transaction to the shadow and queue what it must produce.
    task automatic lookup_and_update(input cal_req_t t);
        int       idx;
        int       lo;
        int       hi;
        int       pick;
        int       n;
        bit       between;
        bit       upper;
        cal_rsp_t r;
        case (t.op)
            OP_WRITE:
            begin
                idx = first_not_below(t.freq);
                if (!(idx < sh_count && sh_key[idx] == t.freq))
                begin
                    if (sh_count >= SLOTS)
                    begin
                        expected_rsp.push_back(status_only(ST_FULL));
                        return;
                    end
                    for (int i = sh_count; i > idx; i--)
                    begin
                        sh_key[i] = sh_key[i-1];
                        sh_sc[i]  = sh_sc[i-1];
                        sh_dl[i]  = sh_dl[i-1];
                        sh_dr[i]  = sh_dr[i-1];
                        sh_di[i]  = sh_di[i-1];
                        sh_ic[i]  = sh_ic[i-1];
                        sh_qi[i]  = sh_qi[i-1];
                    end
                    for (int k = 0; k < TAPS; k++)
                    begin
                        sh_ic[idx][k] = '0;
                        sh_qi[idx][k] = '0;
                    end
                    sh_key[idx] = t.freq;
                    sh_count++;
                end
                sh_sc[idx] = t.sc;
                sh_dl[idx] = t.dl;
                sh_dr[idx] = t.dr;
                sh_di[idx] = t.di;
                sh_ic[idx][t.tap] = t.ic;
                sh_qi[idx][t.tap] = t.qi;
                expected_rsp.push_back(status_only(ST_OK));
            end
            OP_CLEAR:
            begin
                sh_count = 0;
                expected_rsp.push_back(status_only(ST_OK));
            end
            OP_QUERY:
            begin
                n = (sh_ntaps == 0) ? 1 : ((sh_ntaps > TAPS) ? TAPS : int'(sh_ntaps));
                if (sh_count == 0)
                begin
                    expected_rsp.push_back(status_only(ST_EMPTY));
                    return;
                end
                idx     = first_not_below(t.freq);
                between = 1'b0;
                upper   = 1'b0;
                if (idx >= sh_count)
                begin
                    lo = sh_count - 1;
                    hi = lo;
                end
                else if (idx == 0)
                begin
                    lo = 0;
                    hi = 0;
                end
                else
                begin
                    lo      = idx - 1;
                    hi      = idx;
                    between = 1'b1;
                    // tie goes to the lower entry
                    upper   = (sh_key[hi] - t.freq) < (t.freq - sh_key[lo]);
                end
                for (int k = 0; k < n; k++)
                begin
                    r.status = ST_OK;
                    r.tap    = k[TIDX_W-1:0];
                    r.last   = (k == n - 1);
                    if (!between)
                    begin
                        r.ic = sh_ic[lo][k];
                        r.qi = sh_qi[lo][k];
                        r.sc = sh_sc[lo];
                        r.dl = sh_dl[lo];
                        r.dr = sh_dr[lo];
                        r.di = sh_di[lo];
                    end
                    else
                    begin
                        // DC offset is blended in both modes
                        r.dr = blend(t.freq, sh_key[lo], sh_dr[lo], sh_key[hi], sh_dr[hi]);
                        r.di = blend(t.freq, sh_key[lo], sh_di[lo], sh_key[hi], sh_di[hi]);
                        if (sh_nearest)
                        begin
                            pick = upper ? hi : lo;
                            r.ic = sh_ic[pick][k];
                            r.qi = sh_qi[pick][k];
                            r.sc = sh_sc[pick];
                            r.dl = sh_dl[pick];
                        end
                        else
                        begin
                            r.ic = blend(t.freq, sh_key[lo], sh_ic[lo][k],
                                         sh_key[hi], sh_ic[hi][k]);
                            r.qi = blend(t.freq, sh_key[lo], sh_qi[lo][k],
                                         sh_key[hi], sh_qi[hi][k]);
                            r.sc = blend(t.freq, sh_key[lo], sh_sc[lo], sh_key[hi], sh_sc[hi]);
                            r.dl = blend(t.freq, sh_key[lo], sh_dl[lo], sh_key[hi], sh_dl[hi]);
                        end
                    end
                    expected_rsp.push_back(r);
                end
            end
            default:
            begin
                // spare op code: no result, no change
            end
        endcase
    endtask

    task automatic report(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Request driver: one transaction held until taken, random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                lookup_and_update(cur_req);
                if (cur_req.op == OP_QUERY)
                    n_queries++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_req.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    cur_req              = pending_req.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.op           <= cur_req.op;
                    req_if.freq_hz      <= cur_req.freq;
                    req_if.tap_index    <= cur_req.tap;
                    req_if.icross_tap   <= cur_req.ic;
                    req_if.qinline_tap  <= cur_req.qi;
                    req_if.scale_val    <= cur_req.sc;
                    req_if.delay_val    <= cur_req.dl;
                    req_if.dc_offset_re <= cur_req.dr;
                    req_if.dc_offset_im <= cur_req.di;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the shadow takes the value as the write is taken.
    always @(posedge clk)
    begin
        reg_wr_t w;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.addr == CFG_MODE)
                    sh_nearest = cfg_if.wdata[0];
                else if (cfg_if.addr == CFG_NTAPS)
                    sh_ntaps = cfg_if.wdata;
                n_regs++;
            end
            if (!cfg_if.valid || cfg_if.ready)
            begin
                if (pending_reg.size() > 0)
                begin
                    w             = pending_reg.pop_front();
                    cfg_if.valid <= 1'b1;
                    cfg_if.addr  <= w.addr;
                    cfg_if.wdata <= w.data;
                end
                else
                begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cal_rsp_t e;
        if (rst_n)
        begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_results++;
                if (expected_rsp.size() == 0)
                begin
                    report("unexpected result transaction", rsp_if.status, -1);
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    if (rsp_if.status !== e.status)
                        report("status", rsp_if.status, e.status);
                    if (rsp_if.out_tap_index !== e.tap)
                        report("out_tap_index", rsp_if.out_tap_index, e.tap);
                    if (rsp_if.out_icross !== e.ic)
                        report("out_icross", rsp_if.out_icross, e.ic);
                    if (rsp_if.out_qinline !== e.qi)
                        report("out_qinline", rsp_if.out_qinline, e.qi);
                    if (rsp_if.out_scaling !== e.sc)
                        report("out_scaling", rsp_if.out_scaling, e.sc);
                    if (rsp_if.out_delay !== e.dl)
                        report("out_delay", rsp_if.out_delay, e.dl);
                    if (rsp_if.out_dc_re !== e.dr)
                        report("out_dc_re", rsp_if.out_dc_re, e.dr);
                    if (rsp_if.out_dc_im !== e.di)
                        report("out_dc_im", rsp_if.out_dc_im, e.di);
                    if (rsp_if.last !== e.last)
                        report("last", rsp_if.last, e.last);
                    if (e.status == ST_FULL)
                        n_full++;
                    if (e.status == ST_EMPTY)
                        n_empty++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_rsp.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] rnd_val();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] rnd_freq();
        return {2'($urandom_range(3)), $urandom};
    endfunction

    function automatic cal_req_t mk_req(logic [1:0] op, logic [FREQ_W-1:0] f,
                                        logic [TIDX_W-1:0] tap);
        cal_req_t t;
        t = '{op: op, freq: f, tap: tap, ic: rnd_val(), qi: rnd_val(), sc: rnd_val(),
              dl: rnd_val(), dr: rnd_val(), di: rnd_val()};
        return t;
    endfunction

    // A new key is followed by writes of its first nt taps; every tap that a
    // later query can read has been written before it.
    task automatic add_entry(input logic [FREQ_W-1:0] f, input int nt);
        for (int k = 0; k < nt; k++)
            pending_req.push_back(mk_req(OP_WRITE, f, k[TIDX_W-1:0]));
        gen_keys.push_back(f);
    endtask

    task automatic add_simple(input logic [1:0] op, input logic [FREQ_W-1:0] f);
        pending_req.push_back(mk_req(op, f, '0));
    endtask

    // Query frequency: mostly near or between known keys, sometimes anywhere.
    function automatic logic [FREQ_W-1:0] aim_freq();
        logic [FREQ_W-1:0] a;
        logic [FREQ_W-1:0] b;
        if (gen_keys.size() == 0 || $urandom_range(9) < 2)
            return rnd_freq();
        a = gen_keys[$urandom_range(gen_keys.size() - 1)];
        b = gen_keys[$urandom_range(gen_keys.size() - 1)];
        case ($urandom_range(4))
            0:       return a;
            1:       return (a >> 1) + (b >> 1) + (a & b & 1);
            2:       return a + FREQ_W'($urandom_range(3)) - FREQ_W'(1);
            default: return (a < b)
                ? a + FREQ_W'(64'(rnd_freq()) % (64'(b) - 64'(a) + 64'd1))
                : b + FREQ_W'(64'(rnd_freq()) % (64'(a) - 64'(b) + 64'd1));
        endcase
    endfunction

    // hold off new transactions until the block has drained completely
    task automatic drain();
        while (pending_req.size() > 0 || req_if.valid || expected_rsp.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(input logic mode, input logic [NT_W-1:0] nt);
        drain();
        pending_reg.push_back('{addr: CFG_MODE, data: NT_W'(mode)});
        pending_reg.push_back('{addr: CFG_NTAPS, data: nt});
        while (pending_reg.size() > 0 || cfg_if.valid)
            @(posedge clk);
    endtask

    task automatic random_phase(input int actions);
        int  pick;
        for (int a = 0; a < actions; a++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                add_entry(rnd_freq(), TAPS);
            else if (pick < 11 && gen_keys.size() > 0)
                // an extra entry close to one that exists
                add_entry(gen_keys[$urandom_range(gen_keys.size() - 1)] +
                          FREQ_W'($urandom_range(40)), TAPS);
            else if (pick < 21 && gen_keys.size() > 0)
                pending_req.push_back(mk_req(OP_WRITE,
                    gen_keys[$urandom_range(gen_keys.size() - 1)], TIDX_W'($urandom)));
            else if (pick < 23)
            begin
                add_simple(OP_CLEAR, rnd_freq());
                gen_keys.delete();
            end
            else if (pick < 25)
                add_simple(OP_SPARE, rnd_freq());
            else
                add_simple(OP_QUERY, aim_freq());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.op           = OP_WRITE;
        req_if.freq_hz      = '0;
        req_if.tap_index    = '0;
        req_if.icross_tap   = '0;
        req_if.qinline_tap  = '0;
        req_if.scale_val    = '0;
        req_if.delay_val    = '0;
        req_if.dc_offset_re = '0;
        req_if.dc_offset_im = '0;
        rsp_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.addr         = '0;
        cfg_if.wdata        = '0;
        sh_count            = 0;
        sh_nearest          = 1'b0;
        sh_ntaps            = NTAPS_RST;
        tx_idle_pct         = 11;
        rx_idle_pct         = 11;
        mismatches          = 0;
        cycles              = 0;
        n_results           = 0;
        n_queries           = 0;
        n_full              = 0;
        n_empty             = 0;
        n_regs              = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, at reset settings: empty table, spare op code, clear,
        // then two entries with random values and queries at and between the edges.
        add_simple(OP_QUERY, '1);
        add_simple(OP_SPARE, '0);
        add_simple(OP_CLEAR, '0);
        add_entry(34'd1000, TAPS);
        add_entry(34'd3000, TAPS);
        add_simple(OP_QUERY, '0);
        add_simple(OP_QUERY, '1);
        add_simple(OP_QUERY, 34'd1000);
        add_simple(OP_QUERY, 34'd2000);
        add_simple(OP_QUERY, 34'd2999);
        drain();

        // nearest mode, a single tap: tie point and both sides of it
        set_regs(1'b1, 5'd1);
        add_simple(OP_QUERY, 34'd2000);
        add_simple(OP_QUERY, 34'd2001);
        add_simple(OP_QUERY, 34'd1999);
        add_entry('1, TAPS);
        add_entry('0, TAPS);
        add_simple(OP_QUERY, 34'h200000000);
        add_simple(OP_QUERY, '1);

        // random content across several settings
        set_regs(1'b0, 5'd16);
        random_phase(22);
        set_regs(1'b1, 5'd7);
        random_phase(18);
        set_regs(1'b0, 5'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(18);
        tx_idle_pct = 11;
        rx_idle_pct = 11;
        set_regs(1'b1, 5'd20);
        random_phase(14);

        // fill every slot with one-tap entries, then one more key is refused;
        // only tap 0 is in use from here on
        set_regs(1'b0, 5'd1);
        add_simple(OP_CLEAR, '0);
        gen_keys.delete();
        for (int i = 0; i < SLOTS + 1; i++)
            add_entry(rnd_freq(), 1);
        random_phase(6);
        drain();

        $display("covered %0d queries, %0d results, %0d table-full, %0d table-empty,",
                 n_queries, n_results, n_full, n_empty);
        $display("%0d register writes over linear and nearest modes; %0d mismatches",
                 n_regs, mismatches);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ict_pkg.sv
sv/ict_ifs.sv
sv/ict_lerp.sv
sv/ict_datapath.sv
sv/ict_ctrl.sv
sv/interpolating_calibration_table_unit.sv
tb/sv/tb_top.sv
